// ----- sv/lsap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lsap_pkg;

	// Fixed shape of the sensor bar
	localparam int SENSORS     = 5;
	localparam int SAMPLE_BITS = 10;
	localparam int CNT_W       = 9;
	localparam int CFG_W       = 8;
	localparam int IDX_OUT_W   = 3;
	localparam int POS_W       = 13;
	localparam int WEIGHT_STEP = 1000;
	localparam int CENTER_POS  = 3000;
	localparam int IDX_W       = $clog2(SENSORS);
	localparam int WT_W        = $clog2(SENSORS * WEIGHT_STEP + 1);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_W-1:0] EXTRA_RESET = 8'd3;

	// Classification of one item, passed from front to back
	typedef struct packed {
		logic             first;
		logic             last;
		logic [CNT_W-1:0] count;
	} tag_t;

	// Position weight of a sensor: (index+1)*1000
	function automatic logic [WT_W-1:0] weight(input logic [IDX_W-1:0] idx);
		weight = WT_W'((int'(idx) + 1) * WEIGHT_STEP);
	endfunction

endpackage
`default_nettype wire

// ----- sv/lsap_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sample vector channel
interface lsap_in_if #(parameter int SAMPLE_BITS = lsap_pkg::SAMPLE_BITS);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sensor_a;
	logic [SAMPLE_BITS-1:0] sensor_b;
	logic [SAMPLE_BITS-1:0] sensor_c;
	logic [SAMPLE_BITS-1:0] sensor_d;
	logic [SAMPLE_BITS-1:0] sensor_e;

	modport source(output valid, sensor_a, sensor_b, sensor_c, sensor_d, sensor_e,
		input ready);
	modport sink(input valid, sensor_a, sensor_b, sensor_c, sensor_d, sensor_e,
		output ready);
endinterface

// Per-sensor result channel
interface lsap_out_if #(parameter int SAMPLE_BITS = lsap_pkg::SAMPLE_BITS);
	logic                               valid;
	logic                               ready;
	logic [lsap_pkg::IDX_OUT_W-1:0]     sensor_index;
	logic [SAMPLE_BITS-1:0]             minimum;
	logic [SAMPLE_BITS-1:0]             maximum;
	logic [SAMPLE_BITS-1:0]             average;
	logic [lsap_pkg::POS_W-1:0]         position;
	logic                               no_line;
	logic                               last;

	modport source(output valid, sensor_index, minimum, maximum, average, position,
		no_line, last, input ready);
	modport sink(input valid, sensor_index, minimum, maximum, average, position,
		no_line, last, output ready);
endinterface
`default_nettype wire

// ----- sv/lsap_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle
module lsap_div #(
	parameter int DVD_W = 24,
	parameter int DVS_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	// Shift in next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ----- sv/lsap_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Small register FIFO between front and back
module lsap_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int DEPTH = lsap_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] fill_q;

	assign full  = (fill_q == CNT_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign dout  = mem_q[rd_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule
`default_nettype wire

// ----- sv/lsap_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Accepts sample vectors, counts the burst and tags first/last items
module lsap_front #(
	parameter int SAMPLE_BITS = lsap_pkg::SAMPLE_BITS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [lsap_pkg::CFG_W-1:0]                 cfg_wdata,
	lsap_in_if.sink                                    samples,
	input  logic                                       full,
	output logic                                       push,
	output lsap_pkg::tag_t                             tag,
	output logic [lsap_pkg::SENSORS*SAMPLE_BITS-1:0]   vec
);

	localparam int CNT_W = lsap_pkg::CNT_W;

	logic [lsap_pkg::CFG_W-1:0] extra_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           cnt_nxt;

	assign samples.ready = !full;
	assign push          = samples.valid && !full;
	assign vec = {samples.sensor_e, samples.sensor_d, samples.sensor_c,
		samples.sensor_b, samples.sensor_a};

	// Classify the item against the burst length
	always_comb begin
		cnt_nxt = cnt_q + 1'b1;
		if (cnt_nxt == '0) cnt_nxt = CNT_W'(1);
		tag.first = (cnt_q == '0);
		tag.count = cnt_nxt;
		tag.last  = (cnt_nxt >= (CNT_W'(extra_q) + CNT_W'(1)));
	end

	// Burst length register and vector counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extra_q <= lsap_pkg::EXTRA_RESET;
			cnt_q   <= '0;
		end else begin
			if (cfg_we) extra_q <= cfg_wdata;
			if (push)   cnt_q   <= tag.last ? '0 : cnt_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- sv/lsap_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Accumulates samples, computes averages and position, emits results
module lsap_back #(
	parameter int SAMPLE_BITS = lsap_pkg::SAMPLE_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     empty,
	input  lsap_pkg::tag_t                           tag,
	input  logic [lsap_pkg::SENSORS*SAMPLE_BITS-1:0] vec,
	output logic                                     pop,
	lsap_out_if.source                               results
);

	localparam int     SENSORS = lsap_pkg::SENSORS;
	localparam int     IDX_W   = lsap_pkg::IDX_W;
	localparam int     CNT_W   = lsap_pkg::CNT_W;
	localparam int     POS_W   = lsap_pkg::POS_W;
	localparam int     SUM_W   = SAMPLE_BITS + 8;
	localparam longint SMAX    = (longint'(1) << SAMPLE_BITS) - 1;
	localparam longint WGT_MAX = SMAX * longint'(lsap_pkg::WEIGHT_STEP)
		* longint'(SENSORS * (SENSORS + 1) / 2);
	localparam int     WGT_W   = $clog2(WGT_MAX + 1);
	localparam int     TOT_W   = $clog2(SMAX * longint'(SENSORS) + 1);
	localparam int     DVS_W   = (TOT_W > CNT_W) ? TOT_W : CNT_W;

	localparam logic [2:0] S_RUN      = 3'd0;
	localparam logic [2:0] S_AVG_GO   = 3'd1;
	localparam logic [2:0] S_AVG_WAIT = 3'd2;
	localparam logic [2:0] S_POS_GO   = 3'd3;
	localparam logic [2:0] S_POS_WAIT = 3'd4;
	localparam logic [2:0] S_EMIT     = 3'd5;

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   out_valid_q;
	logic                   out_free;
	logic                   idx_end;

	logic [SUM_W-1:0]       sum_q [SENSORS];
	logic [SAMPLE_BITS-1:0] min_q [SENSORS];
	logic [SAMPLE_BITS-1:0] max_q [SENSORS];
	logic [SAMPLE_BITS-1:0] avg_q [SENSORS];
	logic [CNT_W-1:0]       count_q;
	logic [TOT_W-1:0]       total_q;
	logic [WGT_W-1:0]       weighted_q;
	logic [POS_W-1:0]       pos_q;
	logic                   none_q;

	logic                   div_start;
	logic [WGT_W-1:0]       div_dvd;
	logic [DVS_W-1:0]       div_dvs;
	logic                   div_done;
	logic [WGT_W-1:0]       div_quo;
	logic [SAMPLE_BITS-1:0] avg_new;

	logic [lsap_pkg::IDX_OUT_W-1:0] o_idx_q;
	logic [SAMPLE_BITS-1:0]         o_min_q;
	logic [SAMPLE_BITS-1:0]         o_max_q;
	logic [SAMPLE_BITS-1:0]         o_avg_q;
	logic [POS_W-1:0]               o_pos_q;
	logic                           o_none_q;
	logic                           o_last_q;

	assign pop      = !empty && (state_q == S_RUN);
	assign out_free = !out_valid_q || results.ready;
	assign idx_end  = (idx_q == IDX_W'(SENSORS - 1));
	assign avg_new  = div_quo[SAMPLE_BITS-1:0];

	// Divider operand selection: burst averages, then the position
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			S_AVG_GO: begin
				div_start = 1'b1;
				div_dvd   = WGT_W'(sum_q[idx_q]);
				div_dvs   = DVS_W'(count_q);
			end
			S_POS_GO: begin
				div_start = (total_q != '0);
				div_dvd   = weighted_q;
				div_dvs   = DVS_W'(total_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	lsap_div #(
		.DVD_W(WGT_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) out_valid_q <= (state_q == S_EMIT);
			unique case (state_q)
				S_RUN: begin
					if (pop && tag.last) begin
						idx_q   <= '0;
						state_q <= S_AVG_GO;
					end
				end
				S_AVG_GO: state_q <= S_AVG_WAIT;
				S_AVG_WAIT: begin
					if (div_done) begin
						if (idx_end) begin
							state_q <= S_POS_GO;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_AVG_GO;
						end
					end
				end
				S_POS_GO: begin
					idx_q   <= '0;
					state_q <= (total_q == '0) ? S_EMIT : S_POS_WAIT;
				end
				S_POS_WAIT: begin
					if (div_done) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (idx_end) begin
							idx_q   <= '0;
							state_q <= S_RUN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

	// Per-sensor running stores
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < SENSORS; i++) begin
				if (tag.first) begin
					sum_q[i] <= SUM_W'(vec[i*SAMPLE_BITS +: SAMPLE_BITS]);
					min_q[i] <= vec[i*SAMPLE_BITS +: SAMPLE_BITS];
					max_q[i] <= vec[i*SAMPLE_BITS +: SAMPLE_BITS];
				end else begin
					sum_q[i] <= sum_q[i] + SUM_W'(vec[i*SAMPLE_BITS +: SAMPLE_BITS]);
					if (vec[i*SAMPLE_BITS +: SAMPLE_BITS] < min_q[i])
						min_q[i] <= vec[i*SAMPLE_BITS +: SAMPLE_BITS];
					if (vec[i*SAMPLE_BITS +: SAMPLE_BITS] > max_q[i])
						max_q[i] <= vec[i*SAMPLE_BITS +: SAMPLE_BITS];
				end
			end
			if (tag.last) count_q <= tag.count;
		end
	end

	// Averages, their total and the weighted sum
	always_ff @(posedge clk) begin
		if (pop && tag.last) begin
			total_q    <= '0;
			weighted_q <= '0;
		end else if (state_q == S_AVG_WAIT && div_done) begin
			avg_q[idx_q] <= avg_new;
			total_q      <= total_q + TOT_W'(avg_new);
			weighted_q   <= weighted_q
				+ WGT_W'(avg_new) * WGT_W'(lsap_pkg::weight(idx_q));
		end
	end

	// Line position
	always_ff @(posedge clk) begin
		if (state_q == S_POS_GO) begin
			none_q <= (total_q == '0);
			pos_q  <= POS_W'(lsap_pkg::CENTER_POS);
		end else if (state_q == S_POS_WAIT && div_done) begin
			pos_q <= div_quo[POS_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (out_free && state_q == S_EMIT) begin
			o_idx_q  <= lsap_pkg::IDX_OUT_W'(idx_q);
			o_min_q  <= min_q[idx_q];
			o_max_q  <= max_q[idx_q];
			o_avg_q  <= avg_q[idx_q];
			o_pos_q  <= pos_q;
			o_none_q <= none_q;
			o_last_q <= idx_end;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.sensor_index = o_idx_q;
	assign results.minimum      = o_min_q;
	assign results.maximum      = o_max_q;
	assign results.average      = o_avg_q;
	assign results.position     = o_pos_q;
	assign results.no_line      = o_none_q;
	assign results.last         = o_last_q;

endmodule
`default_nettype wire

// ----- sv/line_sensor_average_and_position_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Line sensor burst averager. Each accepted item is one vector of five
// reflectance samples; a burst is cfg_wdata+1 vectors (3 after reset, so four).
// Mid-burst items enter the accumulator one per cycle while no burst end is in
// progress, and produce no result. The item that closes a burst starts up to six
// divisions on one shared restoring divider that yields one quotient bit per
// cycle: five sensor averages and then the centroid, which is skipped when every
// average is zero. The burst end holds the accumulator meanwhile; a two-entry
// queue in front takes up to two items in that time. After the burst end come
// five results, sensor 0 first, each with min, max, average and the shared
// position (3000 with no_line set when every average is zero); last marks the
// fifth. Write cfg only while no burst end is in progress.
module line_sensor_average_and_position_core #(
	parameter int SAMPLE_BITS = lsap_pkg::SAMPLE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lsap_pkg::CFG_W-1:0] cfg_wdata,
	lsap_in_if.sink                    samples,
	lsap_out_if.source                 results
);

	localparam int VEC_W = lsap_pkg::SENSORS * SAMPLE_BITS;
	localparam int TAG_W = $bits(lsap_pkg::tag_t);

	logic                 q_full;
	logic                 q_empty;
	logic                 q_push;
	logic                 q_pop;
	lsap_pkg::tag_t       in_tag;
	lsap_pkg::tag_t       out_tag;
	logic [VEC_W-1:0]     in_vec;
	logic [VEC_W-1:0]     out_vec;
	logic [TAG_W+VEC_W-1:0] q_dout;

	lsap_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.samples  (samples),
		.full     (q_full),
		.push     (q_push),
		.tag      (in_tag),
		.vec      (in_vec)
	);

	lsap_queue #(
		.W(TAG_W + VEC_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   ({in_tag, in_vec}),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign out_tag = q_dout[TAG_W+VEC_W-1:VEC_W];
	assign out_vec = q_dout[VEC_W-1:0];

	lsap_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.tag    (out_tag),
		.vec    (out_vec),
		.pop    (q_pop),
		.results(results)
	);

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import lsap_pkg::*;

	// Worst burst end is six serial divisions plus output; round up
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SHOW_MAX     = 10;

	typedef logic [0:SENSORS-1][SAMPLE_BITS-1:0] vec_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0]   sensor_index;
		logic [SAMPLE_BITS-1:0] minimum;
		logic [SAMPLE_BITS-1:0] maximum;
		logic [SAMPLE_BITS-1:0] average;
		logic [POS_W-1:0]       position;
		logic                   no_line;
		logic                   last;
	} sensor_result_t;

	// One directed item; pos/nl are typed in only where the burst is flat
	typedef struct packed {
		logic             do_cfg;
		logic [CFG_W-1:0] cfg;
		vec_t             s;
		logic             typed;
		logic [POS_W-1:0] pos;
		logic             nl;
	} row_t;

	typedef enum int {MIX_NORMAL, MIX_DARK, MIX_SINGLE} mix_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	lsap_in_if  samples_if ();
	lsap_out_if results_if ();

	line_sensor_average_and_position_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.samples(samples_if),
		.results(results_if)
	);

	// Burst accumulator mirror
	logic [CFG_W-1:0]       burst_extra;
	logic [SAMPLE_BITS+7:0] acc_sum [SENSORS];
	logic [SAMPLE_BITS-1:0] acc_min [SENSORS];
	logic [SAMPLE_BITS-1:0] acc_max [SENSORS];
	logic [CNT_W-1:0]       acc_count;
	sensor_result_t         burst_out [SENSORS];
	sensor_result_t         pending_results [$];

	int n_vectors = 0;
	int n_bursts  = 0;
	int n_dark    = 0;
	int n_results = 0;
	int n_cfg     = 0;
	int n_errors  = 0;
	int cycle_count = 0;

	row_t directed_rows [24] = '{
		'{1'b0, 8'd0,   '{0, 0, 0, 0, 0},              1'b1, 13'd3000, 1'b1},
		'{1'b0, 8'd0,   '{0, 0, 0, 0, 0},              1'b1, 13'd3000, 1'b1},
		'{1'b0, 8'd0,   '{0, 0, 0, 0, 0},              1'b1, 13'd3000, 1'b1},
		'{1'b0, 8'd0,   '{0, 0, 0, 0, 0},              1'b1, 13'd3000, 1'b1},
		'{1'b1, 8'd0,   '{1000, 0, 0, 0, 0},           1'b1, 13'd1000, 1'b0},
		'{1'b0, 8'd0,   '{0, 0, 0, 0, 1000},           1'b1, 13'd5000, 1'b0},
		'{1'b0, 8'd0,   '{1000, 1000, 1000, 1000, 1000}, 1'b1, 13'd3000, 1'b0},
		'{1'b0, 8'd0,   '{1023, 1023, 1023, 1023, 1023}, 1'b1, 13'd3000, 1'b0},
		'{1'b0, 8'd0,   '{0, 0, 1, 0, 0},              1'b1, 13'd3000, 1'b0},
		'{1'b0, 8'd0,   '{1, 0, 0, 0, 0},              1'b1, 13'd1000, 1'b0},
		'{1'b0, 8'd0,   '{0, 1023, 0, 0, 1023},        1'b1, 13'd3500, 1'b0},
		'{1'b0, 8'd0,   '{682, 341, 682, 341, 682},    1'b0, 13'd0,    1'b0},
		'{1'b0, 8'd0,   '{341, 682, 341, 682, 341},    1'b0, 13'd0,    1'b0},
		'{1'b1, 8'd1,   '{1000, 500, 0, 1023, 7},      1'b0, 13'd0,    1'b0},
		'{1'b0, 8'd0,   '{0, 501, 1000, 3, 8},         1'b0, 13'd0,    1'b0},
		'{1'b1, 8'd255, '{12, 900, 450, 1023, 0},      1'b0, 13'd0,    1'b0},
		'{1'b0, 8'd0,   '{1000, 1000, 0, 0, 1},        1'b0, 13'd0,    1'b0},
		'{1'b0, 8'd0,   '{0, 0, 1000, 1000, 1},        1'b0, 13'd0,    1'b0},
		'{1'b0, 8'd0,   '{513, 256, 128, 64, 32},      1'b0, 13'd0,    1'b0},
		'{1'b0, 8'd0,   '{17, 33, 65, 129, 257},       1'b0, 13'd0,    1'b0},
		// shorter burst written mid-burst: this item closes it at six vectors
		'{1'b1, 8'd1,   '{1, 2, 3, 4, 5},              1'b0, 13'd0,    1'b0},
		'{1'b1, 8'd2,   '{1, 1, 1, 0, 1000},           1'b0, 13'd0,    1'b0},
		'{1'b0, 8'd0,   '{0, 1, 1, 0, 1000},           1'b0, 13'd0,    1'b0},
		'{1'b0, 8'd0,   '{0, 0, 1, 1, 1000},           1'b0, 13'd0,    1'b0}
	};

	logic [CFG_W-1:0] phase_extra [14] = '{0, 1, 3, 255, 2, 7, 0, 5, 15, 1, 4, 6, 0, 9};

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Fold one vector into the burst; returns 1 and fills burst_out when it closes
	function automatic bit fold_vector(input vec_t v);
		int unsigned     avg [SENSORS];
		longint unsigned total;
		longint unsigned weighted;
		int unsigned     pos;
		bit              dark;
		total    = 0;
		weighted = 0;
		for (int i = 0; i < SENSORS; i++) begin
			if (acc_count == 0) begin
				acc_sum[i] = v[i];
				acc_min[i] = v[i];
				acc_max[i] = v[i];
			end else begin
				acc_sum[i] = acc_sum[i] + v[i];
				if (v[i] < acc_min[i]) acc_min[i] = v[i];
				if (v[i] > acc_max[i]) acc_max[i] = v[i];
			end
		end
		acc_count = acc_count + 1'b1;
		if (acc_count == 0) acc_count = 1;
		if (acc_count < burst_extra + 1) return 1'b0;

		for (int i = 0; i < SENSORS; i++) begin
			avg[i]   = acc_sum[i] / acc_count;
			total    += avg[i];
			weighted += longint'(avg[i]) * (i + 1) * WEIGHT_STEP;
		end
		dark = (total == 0);
		pos  = dark ? CENTER_POS : int'(weighted / total);
		for (int i = 0; i < SENSORS; i++) begin
			burst_out[i] = '{IDX_OUT_W'(i), acc_min[i], acc_max[i], SAMPLE_BITS'(avg[i]),
				POS_W'(pos), dark, (i == SENSORS - 1)};
			acc_sum[i] = '0;
			acc_min[i] = '0;
			acc_max[i] = '0;
		end
		acc_count = '0;
		return 1'b1;
	endfunction

	// Random sample vector of the given burst flavor
	function automatic vec_t draw_vector(input mix_t mix, input int lit);
		vec_t v;
		int   r;
		for (int i = 0; i < SENSORS; i++) begin
			r = $urandom_range(0, 19);
			case (mix)
				MIX_DARK: v[i] = '0;
				MIX_SINGLE: v[i] = (i == lit) ? SAMPLE_BITS'($urandom_range(1, 1023)) : '0;
				default: begin
					if (r < 14) v[i] = SAMPLE_BITS'($urandom_range(0, 1000));
					else if (r < 17) v[i] = SAMPLE_BITS'($urandom_range(0, 1023));
					else if (r == 17) v[i] = '0;
					else if (r == 18) v[i] = SAMPLE_BITS'(1000);
					else v[i] = '1;
				end
			endcase
		end
		return v;
	endfunction

	// Offer one item, wait for the handshake, then record its expected results
	task automatic send_vector(input vec_t v, input bit has_typed,
		input logic [POS_W-1:0] typed_pos, input logic typed_nl, input bit fast);
		int gap;
		gap = fast ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid    <= 1'b1;
		samples_if.sensor_a <= v[0];
		samples_if.sensor_b <= v[1];
		samples_if.sensor_c <= v[2];
		samples_if.sensor_d <= v[3];
		samples_if.sensor_e <= v[4];
		do @(posedge clk); while (!samples_if.ready);
		n_vectors++;
		if (fold_vector(v)) begin
			n_bursts++;
			if (burst_out[0].no_line) n_dark++;
			for (int i = 0; i < SENSORS; i++) begin
				if (has_typed) begin
					burst_out[i].minimum  = v[i];
					burst_out[i].maximum  = v[i];
					burst_out[i].average  = v[i];
					burst_out[i].position = typed_pos;
					burst_out[i].no_line  = typed_nl;
				end
				pending_results.push_back(burst_out[i]);
			end
		end
	endtask

	// Hold off the sender until every expected result is out
	task automatic wait_results_drained();
		samples_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Idle the block fully: results out, queued mid-burst items absorbed
	task automatic settle_block();
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_burst_length(input logic [CFG_W-1:0] extra);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= extra;
		@(posedge clk);
		cfg_we      <= 1'b0;
		burst_extra = extra;
		n_cfg++;
	endtask

	// Result sink: check each item, then draw the next stall
	int             stall_left = 0;
	int             recv_gap;
	bit             fast_recv = 1'b0;
	sensor_result_t got;
	sensor_result_t want;

	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			stall_left       <= 0;
		end else if (results_if.valid && results_if.ready) begin
			got = '{results_if.sensor_index, results_if.minimum, results_if.maximum,
				results_if.average, results_if.position, results_if.no_line, results_if.last};
			n_results++;
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= SHOW_MAX)
					$display("unexpected result: idx=%0d min=%0d max=%0d avg=%0d pos=%0d",
						got.sensor_index, got.minimum, got.maximum, got.average, got.position);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					n_errors++;
					if (n_errors <= SHOW_MAX) begin
						$display("mismatch exp: idx=%0d min=%0d max=%0d avg=%0d pos=%0d nl=%0d last=%0d",
							want.sensor_index, want.minimum, want.maximum, want.average,
							want.position, want.no_line, want.last);
						$display("         got: idx=%0d min=%0d max=%0d avg=%0d pos=%0d nl=%0d last=%0d",
							got.sensor_index, got.minimum, got.maximum, got.average,
							got.position, got.no_line, got.last);
					end
				end
			end
			if ($urandom_range(0, 31) == 0) fast_recv = !fast_recv;
			recv_gap = fast_recv ? 0 : $urandom_range(0, 7);
			stall_left       <= recv_gap;
			results_if.ready <= (recv_gap == 0);
		end else if (stall_left > 0) begin
			stall_left       <= stall_left - 1;
			results_if.ready <= (stall_left == 1);
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d results outstanding", pending_results.size());
			$display("line_sensor_average_and_position_core regression: fail");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int   n_items;
		int   lit;
		int   r;
		bit   fast;
		mix_t mix;

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		samples_if.valid    = 1'b0;
		samples_if.sensor_a = '0;
		samples_if.sensor_b = '0;
		samples_if.sensor_c = '0;
		samples_if.sensor_d = '0;
		samples_if.sensor_e = '0;
		burst_extra         = EXTRA_RESET;
		acc_count           = '0;
		for (int i = 0; i < SENSORS; i++) begin
			acc_sum[i] = '0;
			acc_min[i] = '0;
			acc_max[i] = '0;
		end
		mix = MIX_NORMAL;
		lit = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset burst length, extremes, position ends, truncation
		foreach (directed_rows[k]) begin
			if (directed_rows[k].do_cfg) write_burst_length(directed_rows[k].cfg);
			send_vector(directed_rows[k].s, directed_rows[k].typed, directed_rows[k].pos,
				directed_rows[k].nl, 1'b0);
		end

		// Random phases; a phase may stop mid-burst before the next length is set
		foreach (phase_extra[p]) begin
			write_burst_length(phase_extra[p]);
			n_items = (phase_extra[p] == 8'd255) ? 256 + $urandom_range(0, 6)
				: $urandom_range(4, 10);
			fast = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < n_items; k++) begin
				if (acc_count == 0) begin
					r   = $urandom_range(0, 9);
					mix = (r == 0) ? MIX_DARK : (r == 1) ? MIX_SINGLE : MIX_NORMAL;
					lit = $urandom_range(0, SENSORS - 1);
				end
				if ($urandom_range(0, 59) == 0) wait_results_drained();
				send_vector(draw_vector(mix, lit), 1'b0, '0, 1'b0, fast);
			end
		end

		settle_block();
		if (pending_results.size() != 0) n_errors++;
		$display("covered %0d sample vectors, %0d bursts (%0d with no line), %0d results",
			n_vectors, n_bursts, n_dark, n_results);
		$display("burst lengths from 1 to 256 over %0d register writes, %0d mismatches",
			n_cfg, n_errors);
		if (n_errors == 0) begin
			$display("line_sensor_average_and_position_core regression: pass");
		end else begin
			$display("line_sensor_average_and_position_core regression: fail");
		end
		$finish;
	end

endmodule
